// File: rtl/ptd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the telemetry word decoder.
// ----------------------------------------------------------------------------
package ptd_pkg;

    // Command codes
    localparam logic [7:0] CMD_VOUT = 8'h8B;
    localparam logic [7:0] CMD_IOUT = 8'h8C;
    localparam logic [7:0] CMD_TEMP = 8'h8D;
    localparam logic [7:0] CMD_POUT = 8'h96;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUS_FAIL = 2'd1;
    localparam logic [1:0] ST_NOT_INIT = 2'd2;

    // Field widths
    localparam int FUNC_W   = 8;
    localparam int RAW_W    = 16;
    localparam int INT_W    = 26;
    localparam int FRAC_W   = 11;
    localparam int STATUS_W = 2;

    // Stream widths
    localparam int S_TDATA_W = RAW_W;
    localparam int S_TUSER_W = FUNC_W + 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = STATUS_W;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [FRAC_W-1:0] fraction_part;
        logic [INT_W-1:0]  integer_part;
    } ptd_value_t;

endpackage

// File: rtl/pmbus_telemetry_decode_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmbus_telemetry_decode_top
// A result transaction passes through the input register, the decode logic
// and the result register, and m_tvalid comes from the result register.
// Throughput: one word per cycle while m_tready is not held low; the
// decode path is a single shift/constant-multiply pass.
// Reset: rst_n clears both pipeline valids and device_ready (reads report
// not initialized until software sets it).
// ----------------------------------------------------------------------------
module pmbus_telemetry_decode_top
    import ptd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] raw_word
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [7:0] func, [8] read_failed

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [25:0] integer_part,
                                             // [36:26] fraction_part, [39:37] 0
    output logic [M_TUSER_W-1:0]  m_tuser,   // [1:0] status

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic dev_ready_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = {{(APB_DATA_W-1){1'b0}}, dev_ready_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_ready_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            dev_ready_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic [FUNC_W-1:0] func_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic              fail_reg;

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            func_reg <= s_tuser[FUNC_W-1:0];
            raw_reg  <= s_tdata;
            fail_reg <= s_tuser[FUNC_W];
        end
    end

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    ptd_value_t        val_next;
    logic [1:0]        status_next;

    logic [10:0]       low11;
    logic              man_neg;
    logic [10:0]       man_mag;
    logic [4:0]        exp_raw;
    logic [4:0]        rshift;
    logic [INT_W-1:0]  lin_whole;
    logic [10:0]       rem_mask;
    logic [10:0]       rem;
    logic [20:0]       rem_milli;
    logic [9:0]        lin_frac;
    logic [INT_W-1:0]  lin_int_s;
    logic [FRAC_W-1:0] lin_frac_s;
    logic [1:0]        vout_whole;
    logic [10:0]       vout_frac;

    always_comb
    begin
        low11   = raw_reg[10:0];
        man_neg = raw_reg[10];
        man_mag = man_neg ? (~low11 + 11'd1) : low11;
        exp_raw = raw_reg[15:11];
        // negative exponent: right shift by 32 - exp_raw (1..16)
        rshift  = ~exp_raw + 5'd1;

        rem_mask  = 11'((17'd1 << rshift) - 17'd1);
        rem       = man_mag & rem_mask;
        // remainder * 1000 as shifts and subtracts
        rem_milli = ({10'd0, rem} << 10) - ({10'd0, rem} << 4) - ({10'd0, rem} << 3);
        // each fraction digit group stays below 1000
        lin_frac  = 10'(rem_milli >> rshift);

        if (exp_raw[4])
        begin
            lin_whole = INT_W'(man_mag >> rshift);
        end
        else
        begin
            lin_whole = INT_W'(man_mag) << exp_raw[3:0];
        end

        lin_int_s = man_neg ? (~lin_whole + INT_W'(1)) : lin_whole;
        if (!exp_raw[4])
        begin
            lin_frac_s = '0;
        end
        else if (man_neg)
        begin
            lin_frac_s = ~{1'b0, lin_frac} + FRAC_W'(1);
        end
        else
        begin
            lin_frac_s = {1'b0, lin_frac};
        end

        // millivolts to volts, low11 is below 2048
        if (low11 >= 11'd2000)
        begin
            vout_whole = 2'd2;
            vout_frac  = low11 - 11'd2000;
        end
        else if (low11 >= 11'd1000)
        begin
            vout_whole = 2'd1;
            vout_frac  = low11 - 11'd1000;
        end
        else
        begin
            vout_whole = 2'd0;
            vout_frac  = low11;
        end

        val_next    = '0;
        status_next = ST_OK;
        if (!dev_ready_reg)
        begin
            status_next = ST_NOT_INIT;
        end
        else if (fail_reg)
        begin
            status_next = ST_BUS_FAIL;
        end
        else
        begin
            case (func_reg)
                CMD_TEMP:
                begin
                    if (!raw_reg[10])
                    begin
                        val_next.integer_part = INT_W'(raw_reg[9:0]);
                    end
                end
                CMD_VOUT:
                begin
                    val_next.integer_part  = INT_W'(vout_whole);
                    val_next.fraction_part = vout_frac;
                end
                CMD_IOUT:
                begin
                    val_next.integer_part  = lin_int_s;
                    val_next.fraction_part = lin_frac_s;
                end
                CMD_POUT:
                begin
                    val_next.integer_part  = INT_W'(low11[10:2]);
                    // quarter watts: 0, 250, 500, 750
                    val_next.fraction_part = FRAC_W'({low11[1:0], 8'd0})
                                           - FRAC_W'({low11[1:0], 2'd0})
                                           - FRAC_W'({low11[1:0], 1'b0});
                end
                default:
                begin
                    val_next = '0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    ptd_value_t  val_reg;
    logic [1:0]  status_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            val_reg    <= val_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, val_reg};
    assign m_tuser  = status_reg;

endmodule

// File: rtl/ptd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the telemetry decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ptd_checker
    import ptd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every accepted word is followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result missing after input transaction");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("nonzero value on error status");

    // integer and fraction parts share the sign of the value
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25:0] != '0 && m_tdata[36:26] != '0
        |-> m_tdata[25] == m_tdata[36])
        else $error("integer and fraction signs disagree");

    // register write is read back
    a_cfg_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && !paddr[2]
        |=> prdata[0] == $past(pwdata[0]))
        else $error("device_ready readback mismatch");

endmodule

bind pmbus_telemetry_decode_top ptd_checker u_ptd_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the telemetry word decoder. Words are streamed in
// with random gaps, and every decoded result is compared field by field
// against an independent fixed-point decoder kept in a small scoreboard.
// device_ready is toggled between phases through the APB port and read back.
// One phase holds off the result side for a long stretch so the pipeline
// backs up into the input.
// ----------------------------------------------------------------------------
module testbench;
    import ptd_pkg::*;

    localparam int                    IDLE_LIMIT       = 5000;
    localparam int                    HOLD_CYCLES      = 300;
    localparam int                    SETTLE_CYCLES    = 4;
    localparam logic [APB_ADDR_W-1:0] REG_DEVICE_READY = '0;

    typedef struct packed {
        logic [INT_W-1:0]    ip;
        logic [FRAC_W-1:0]   fp;
        logic [STATUS_W-1:0] st;
    } decoded_t;

    class telemetry_scoreboard;
        decoded_t expected_values[$];
        bit       ready;
        int       errors;

        function new();
            ready  = 1'b0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_ready(bit value);
            ready = value;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        // Fixed-point decode of one telemetry word
        function decoded_t decode_word(logic [7:0] func, logic [15:0] raw, logic failed);
            decoded_t         r;
            logic [10:0]      low11;
            logic [4:0]       ex;
            logic             neg;
            logic [11:0]      mag;
            logic [INT_W-1:0] whole_v;
            logic [21:0]      milli;
            logic [10:0]      frac_v;
            int               shamt;
            r     = '0;
            low11 = raw[10:0];
            if (!ready)
                r.st = ST_NOT_INIT;
            else if (failed)
                r.st = ST_BUS_FAIL;
            else begin
                r.st = ST_OK;
                case (func)
                    CMD_TEMP:
                    begin
                        if (!raw[10])
                            r.ip = INT_W'(raw[9:0]);
                    end
                    CMD_VOUT:
                    begin
                        r.ip = INT_W'(low11 / 1000);
                        r.fp = FRAC_W'(low11 % 1000);
                    end
                    CMD_IOUT:
                    begin
                        // mantissa is two's complement, work on its magnitude
                        neg = raw[10];
                        mag = neg ? (12'd2048 - {1'b0, low11}) : {1'b0, low11};
                        ex  = raw[15:11];
                        if (!ex[4]) begin
                            whole_v = INT_W'(mag) << ex;
                            r.ip    = neg ? -whole_v : whole_v;
                        end
                        else begin
                            shamt   = 32 - int'(ex);
                            whole_v = INT_W'(mag >> shamt);
                            milli   = (22'(mag) * 22'd1000) >> shamt;
                            frac_v  = 11'(milli % 1000);
                            r.ip    = neg ? -whole_v : whole_v;
                            r.fp    = neg ? -frac_v : frac_v;
                        end
                    end
                    CMD_POUT:
                    begin
                        r.ip = INT_W'(low11 >> 2);
                        r.fp = FRAC_W'(low11[1:0]) * 11'd250;
                    end
                    default: ;
                endcase
            end
            return r;
        endfunction

        function void note_word(logic [7:0] func, logic [15:0] raw, logic failed);
            expected_values.push_back(decode_word(func, raw, failed));
        endfunction

        task check_result(logic [INT_W-1:0] ip, logic [FRAC_W-1:0] fp,
                          logic [STATUS_W-1:0] st);
            decoded_t exp_r;
            if (expected_values.size() == 0) begin
                report_mismatch($sformatf("unexpected result int=%0d frac=%0d status=%0d",
                                          $signed(ip), $signed(fp), st));
                return;
            end
            exp_r = expected_values.pop_front();
            if (ip !== exp_r.ip)
                report_mismatch($sformatf("integer_part got %0d exp %0d",
                                          $signed(ip), $signed(exp_r.ip)));
            if (fp !== exp_r.fp)
                report_mismatch($sformatf("fraction_part got %0d exp %0d",
                                          $signed(fp), $signed(exp_r.fp)));
            if (st !== exp_r.st)
                report_mismatch($sformatf("status got %0d exp %0d", st, exp_r.st));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [15:0] raw_word
    logic [S_TUSER_W-1:0]  s_tuser  = '0;   // [7:0] func, [8] read_failed
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // [25:0] integer_part, [36:26] fraction_part
    logic [M_TUSER_W-1:0]  m_tuser;         // [1:0] status
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    telemetry_scoreboard sb;
    bit                  no_idle     = 1'b0;
    bit                  hold_output = 1'b0;
    int                  idle_cycles = 0;

    pmbus_telemetry_decode_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Ends on a long run of cycles with no transaction on either stream or the APB port
    initial
    begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stall per transaction, one long hold-off on request
    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata[INT_W-1:0], m_tdata[INT_W+FRAC_W-1:INT_W],
                            m_tuser[STATUS_W-1:0]);
        end
    end

    task send_word(logic [7:0] func, logic [15:0] raw, logic failed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= {failed, func};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(func, raw, failed);
    endtask

    task send_random_word();
        logic [7:0]  func;
        logic [15:0] raw;
        logic        failed;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
                0:       func = CMD_TEMP;
                1:       func = CMD_VOUT;
                2:       func = CMD_IOUT;
                default: func = CMD_POUT;
            endcase
        end
        else
            func = 8'($urandom_range(0, 255));
        raw    = 16'($urandom_range(0, 65535));
        failed = ($urandom_range(0, 9) == 0);
        send_word(func, raw, failed);
    endtask

    // Waits until every result is back, then lets the pipeline settle
    task drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task apb_access(bit write, logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] wdata,
                    output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task set_device_ready(bit value);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b1, REG_DEVICE_READY, APB_DATA_W'(value), rdata);
        sb.set_ready(value);
        apb_access(1'b0, REG_DEVICE_READY, '0, rdata);
        if (rdata[0] !== value)
            sb.report_mismatch($sformatf("device_ready readback got %0d exp %0d",
                                         rdata[0], value));
    endtask

    initial
    begin
        bit ready_v;
        int count;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the device is not initialized; this wins over a bus failure
        send_word(CMD_TEMP, 16'h0123, 1'b0);
        send_word(CMD_IOUT, 16'hFFFF, 1'b1);
        send_word(8'h00, 16'h0000, 1'b0);
        drain_results();

        set_device_ready(1'b1);
        send_word(CMD_TEMP, 16'h0000, 1'b0);
        send_word(CMD_TEMP, 16'h03FF, 1'b0);
        send_word(CMD_TEMP, 16'h0400, 1'b0);   // bit 10 forces zero
        send_word(CMD_TEMP, 16'hFBFF, 1'b0);   // reserved bits ignored
        send_word(CMD_TEMP, 16'hFFFF, 1'b0);
        send_word(CMD_VOUT, 16'h0000, 1'b0);
        send_word(CMD_VOUT, 16'h07FF, 1'b0);
        send_word(CMD_VOUT, 16'h03E8, 1'b0);
        send_word(CMD_VOUT, 16'hFFFF, 1'b0);
        send_word(CMD_IOUT, 16'h0000, 1'b0);
        send_word(CMD_IOUT, 16'h7BFF, 1'b0);   // largest positive, exponent +15
        send_word(CMD_IOUT, 16'h7C00, 1'b0);   // most negative, exponent +15
        send_word(CMD_IOUT, 16'h8400, 1'b0);   // -1024 * 2^-16
        send_word(CMD_IOUT, 16'hFBFF, 1'b0);   // 1023 * 2^-1
        send_word(CMD_IOUT, 16'h87FF, 1'b0);   // -1 * 2^-16
        send_word(CMD_IOUT, 16'h07FF, 1'b0);   // -1, exponent zero
        send_word(CMD_IOUT, 16'hF401, 1'b0);   // small mantissa, exponent -2
        send_word(CMD_POUT, 16'h0000, 1'b0);
        send_word(CMD_POUT, 16'h07FF, 1'b0);
        send_word(CMD_POUT, 16'hF803, 1'b0);
        send_word(8'h00, 16'h1234, 1'b0);      // unsupported codes decode to zero
        send_word(8'hFF, 16'hFFFF, 1'b0);
        send_word(CMD_IOUT, 16'h7BFF, 1'b1);   // bus failure
        send_word(CMD_VOUT, 16'h07FF, 1'b1);
        drain_results();

        for (int p = 0; p < 8; p++) begin
            ready_v = !(p == 2 || p == 5);
            set_device_ready(ready_v);
            no_idle = (p % 3 == 1);
            count   = ready_v ? 90 : 30;
            if (p == 3)
                hold_output = 1'b1;
            repeat (count) send_random_word();
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: pmbus_telemetry_decode_top.f
rtl/ptd_pkg.sv
rtl/pmbus_telemetry_decode_top.sv
rtl/ptd_checker.sv
bench/testbench.sv
